/* rtl/sega_pkg.sv */
// Shared types, codes and defaults for the segment allocator.
package sega_pkg;

    localparam int unsigned MAX_SEGMENTS_DEF = 16;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned STAT_W  = 3;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE    = 3'd1;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND   = 3'd3;
    localparam logic [STAT_W-1:0] ST_WRONG_STATE = 3'd4;
    localparam logic [STAT_W-1:0] ST_ZERO_SIZE   = 3'd5;

    localparam logic CMD_ALLOC  = 1'b0;
    localparam logic CMD_CHANGE = 1'b1;

    localparam logic [PHASE_W-1:0] PH_FREE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_NEW    = 2'd1;
    localparam logic [PHASE_W-1:0] PH_ACTIVE = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DONE   = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0]  lo_off;
        logic [DATA_W-1:0]  hi_off;
        logic [PHASE_W-1:0] phase;
    } t_seg;

    localparam int unsigned SEG_W = $bits(t_seg);

    localparam int unsigned IN_TDATA_W  = 104;
    localparam int unsigned OUT_TDATA_W = 72;

endpackage

/* rtl/sega_ram.sv */
// Generic simple dual-port RAM with registered read.
module sega_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/segment_allocator_with_lifecycle.sv */
// Segment allocator: sorted range table in RAM with per-range lifecycle phase.
// One request at a time. An allocate scans one entry per cycle behind the RAM read
// latency (skipped on an empty table), shifts up where needed, then writes the range;
// a change scans and writes the new phase or, on a free, shifts down where needed.
// Errors caught before the scan go straight to the completion state. A new request
// is taken while the result waits in its register.
// Reset clears capacity, range count and control; table contents stay as-is.
module segment_allocator_with_lifecycle #(
    parameter int unsigned MAX_SEGMENTS = sega_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [sega_pkg::DATA_W-1:0]        i_cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] request_size, [63:32] range_start, [95:64] range_end,
    // [97:96] target_state, [103:98] zero
    input  logic [sega_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] command
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] status, [34:3] given_start, [66:35] given_end, [71:67] zero
    output logic [sega_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);
    localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned DW    = sega_pkg::DATA_W;
    localparam int unsigned SW    = sega_pkg::STAT_W;
    localparam int unsigned PW    = sega_pkg::PHASE_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHUP  = 3'd2;
    localparam logic [2:0] S_SHDN  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]       r_state,    n_state;
    logic [CNT_W-1:0] r_count,    n_count;
    logic [DW-1:0]    r_capacity;
    logic             r_out_vld,  n_out_vld;
    logic             r_rd_live,  n_rd_live;
    logic             r_rd_end,   n_rd_end;
    logic [IDX_W-1:0] r_rd_addr,  n_rd_addr;
    logic [IDX_W-1:0] r_rd_idx;

    logic             r_cmd,      n_cmd;
    logic [DW-1:0]    r_size,     n_size;
    logic [DW-1:0]    r_rs,       n_rs;
    logic [DW-1:0]    r_re,       n_re;
    logic [PW-1:0]    r_tgt,      n_tgt;
    logic [DW-1:0]    r_prev,     n_prev;
    logic [IDX_W-1:0] r_pos,      n_pos;
    logic [DW-1:0]    r_base,     n_base;
    logic [SW-1:0]    r_status,   n_status;
    logic [DW-1:0]    r_gs,       n_gs;
    logic [DW-1:0]    r_ge,       n_ge;
    logic [SW-1:0]    r_o_status, n_o_status;
    logic [DW-1:0]    r_o_gs,     n_o_gs;
    logic [DW-1:0]    r_o_ge,     n_o_ge;

    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    sega_pkg::t_seg             wr_seg;
    logic [sega_pkg::SEG_W-1:0] rd_raw;
    sega_pkg::t_seg             rd_seg;

    logic             issue;
    logic [IDX_W-1:0] last_idx;
    logic             is_last;
    logic [DW:0]      sum_prev;
    logic [DW:0]      sum_last;
    logic             fit_here;
    logic             hit;
    logic [DW-1:0]    in_size;

    sega_ram #(
        .WIDTH (sega_pkg::SEG_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_seg),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_raw)
    );

    assign rd_seg   = sega_pkg::t_seg'(rd_raw);
    assign in_size  = s_axis_tdata[31:0];
    assign last_idx = IDX_W'(r_count - CNT_W'(1));
    assign is_last  = (r_rd_idx == last_idx);
    assign sum_prev = {1'b0, r_prev} + {1'b0, r_size};
    assign sum_last = {1'b0, rd_seg.hi_off} + {1'b0, r_size};
    assign fit_here = (r_rd_idx == '0) ? (r_size <= rd_seg.lo_off)
                                       : (sum_prev <= {1'b0, rd_seg.lo_off});
    assign hit      = (rd_seg.lo_off == r_rs) && (rd_seg.hi_off == r_re);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_o_ge, r_o_gs, r_o_status};

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_out_vld  = r_out_vld & ~m_axis_tready;
        n_rd_end   = r_rd_end;
        n_rd_addr  = r_rd_addr;
        n_cmd      = r_cmd;
        n_size     = r_size;
        n_rs       = r_rs;
        n_re       = r_re;
        n_tgt      = r_tgt;
        n_prev     = r_prev;
        n_pos      = r_pos;
        n_base     = r_base;
        n_status   = r_status;
        n_gs       = r_gs;
        n_ge       = r_ge;
        n_o_status = r_o_status;
        n_o_gs     = r_o_gs;
        n_o_ge     = r_o_ge;
        wr_en      = 1'b0;
        wr_addr    = r_pos;
        wr_seg     = rd_seg;
        issue      = 1'b0;
        n_rd_live  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd     = s_axis_tuser;
                    n_size    = in_size;
                    n_rs      = s_axis_tdata[63:32];
                    n_re      = s_axis_tdata[95:64];
                    n_tgt     = s_axis_tdata[97:96];
                    n_rd_addr = '0;
                    n_rd_end  = 1'b0;
                    n_prev    = '0;
                    n_gs      = '0;
                    n_ge      = '0;
                    n_state   = S_DONE;
                    if (s_axis_tuser == sega_pkg::CMD_ALLOC) begin
                        priority if (in_size == '0) begin
                            n_status = sega_pkg::ST_ZERO_SIZE;
                        end else if (r_count == CNT_W'(MAX_SEGMENTS)) begin
                            n_status = sega_pkg::ST_TABLE_FULL;
                        end else if (r_count == '0) begin
                            if (in_size <= r_capacity) begin
                                n_pos   = '0;
                                n_base  = '0;
                                n_state = S_WRITE;
                            end else begin
                                n_status = sega_pkg::ST_NO_SPACE;
                            end
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = sega_pkg::ST_NOT_FOUND;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                issue     = ~r_rd_end;
                n_rd_addr = r_rd_addr + IDX_W'(1);
                n_rd_end  = r_rd_end | (r_rd_addr == last_idx);
                if (r_rd_live) begin
                    if (r_cmd == sega_pkg::CMD_ALLOC) begin
                        n_prev = rd_seg.hi_off;
                        if (fit_here) begin
                            n_base    = (r_rd_idx == '0) ? '0 : r_prev;
                            n_pos     = r_rd_idx;
                            n_rd_addr = last_idx;
                            n_rd_end  = 1'b0;
                            issue     = 1'b0;
                            n_state   = S_SHUP;
                        end else if (is_last) begin
                            issue = 1'b0;
                            if (sum_last <= {1'b0, r_capacity}) begin
                                n_base  = rd_seg.hi_off;
                                n_pos   = IDX_W'(r_count);
                                n_state = S_WRITE;
                            end else begin
                                n_status = sega_pkg::ST_NO_SPACE;
                                n_state  = S_DONE;
                            end
                        end
                    end else begin
                        if (hit) begin
                            issue    = 1'b0;
                            n_state  = S_DONE;
                            n_status = sega_pkg::ST_OK;
                            if (r_tgt == sega_pkg::PH_FREE &&
                                rd_seg.phase == sega_pkg::PH_DONE) begin
                                if (is_last) begin
                                    n_count = r_count - CNT_W'(1);
                                end else begin
                                    n_rd_addr = r_rd_idx + IDX_W'(1);
                                    n_rd_end  = 1'b0;
                                    n_state   = S_SHDN;
                                end
                            end else if ((r_tgt == sega_pkg::PH_ACTIVE &&
                                          rd_seg.phase == sega_pkg::PH_NEW) ||
                                         (r_tgt == sega_pkg::PH_DONE &&
                                          rd_seg.phase == sega_pkg::PH_ACTIVE)) begin
                                wr_en        = 1'b1;
                                wr_addr      = r_rd_idx;
                                wr_seg.phase = r_tgt;
                            end else begin
                                n_status = sega_pkg::ST_WRONG_STATE;
                            end
                        end else if (is_last) begin
                            issue    = 1'b0;
                            n_status = sega_pkg::ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end
                    end
                end
                n_rd_live = issue;
            end
            S_SHUP: begin
                issue     = ~r_rd_end;
                n_rd_addr = r_rd_addr - IDX_W'(1);
                n_rd_end  = r_rd_end | (r_rd_addr == r_pos);
                if (r_rd_live) begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_idx + IDX_W'(1);
                    if (r_rd_idx == r_pos) begin
                        issue   = 1'b0;
                        n_state = S_WRITE;
                    end
                end
                n_rd_live = issue;
            end
            S_SHDN: begin
                issue     = ~r_rd_end;
                n_rd_addr = r_rd_addr + IDX_W'(1);
                n_rd_end  = r_rd_end | (r_rd_addr == last_idx);
                if (r_rd_live) begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_idx - IDX_W'(1);
                    if (is_last) begin
                        issue    = 1'b0;
                        n_count  = r_count - CNT_W'(1);
                        n_status = sega_pkg::ST_OK;
                        n_state  = S_DONE;
                    end
                end
                n_rd_live = issue;
            end
            S_WRITE: begin
                wr_en         = 1'b1;
                wr_addr       = r_pos;
                wr_seg.lo_off = r_base;
                wr_seg.hi_off = r_base + r_size;
                wr_seg.phase  = sega_pkg::PH_NEW;
                n_count       = r_count + CNT_W'(1);
                n_status      = sega_pkg::ST_OK;
                n_gs          = r_base;
                n_ge          = r_base + r_size;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_o_status = r_status;
                    n_o_gs     = r_gs;
                    n_o_ge     = r_ge;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_capacity <= '0;
            r_out_vld  <= 1'b0;
            r_rd_live  <= 1'b0;
            r_rd_end   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
            r_rd_live <= n_rd_live;
            r_rd_end  <= n_rd_end;
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr  <= n_rd_addr;
        r_rd_idx   <= r_rd_addr;
        r_cmd      <= n_cmd;
        r_size     <= n_size;
        r_rs       <= n_rs;
        r_re       <= n_re;
        r_tgt      <= n_tgt;
        r_prev     <= n_prev;
        r_pos      <= n_pos;
        r_base     <= n_base;
        r_status   <= n_status;
        r_gs       <= n_gs;
        r_ge       <= n_ge;
        r_o_status <= n_o_status;
        r_o_gs     <= n_o_gs;
        r_o_ge     <= n_o_ge;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SEGMENTS))
        else $error("range count beyond table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CNT_W'(1) ||
             r_count == $past(r_count) - CNT_W'(1)))
        else $error("range count moved by more than one");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_DONE))
        else $error("result raised outside completion");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !wr_en)
        else $error("table written while no request in progress");

endmodule
